// ----- sv/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge, off while reset is low
`define BSS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// plain check with no reset gating
`define BSS_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/bss_pkg.sv -----
package bss_pkg;

	localparam logic [5:0] OPC_B  = 6'd18;
	localparam logic [5:0] OPC_BC = 6'd16;
	localparam logic [5:0] OPC_XL = 6'd19;

	localparam logic [9:0] XO_BCLR  = 10'd16;
	localparam logic [9:0] XO_BCCTR = 10'd528;

	localparam logic [31:0] PC_STEP = 32'd4;

	typedef struct packed {
		logic [31:0] instr_word;
		logic [31:0] pc_value;
		logic [31:0] link_value;
		logic [31:0] count_value;
		logic [31:0] cond_value;
	} req_item_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic [31:0] next_link;
		logic [31:0] next_count;
		logic        taken;
		logic        not_branch;
	} rsp_item_t;

endpackage

// ----- sv/bss_req_if.sv -----
interface bss_req_if;
	logic        valid;
	logic        ready;
	logic [31:0] instr_word;
	logic [31:0] pc_value;
	logic [31:0] link_value;
	logic [31:0] count_value;
	logic [31:0] cond_value;

	modport source (
		output valid, instr_word, pc_value, link_value, count_value, cond_value,
		input  ready
	);
	modport sink (
		input  valid, instr_word, pc_value, link_value, count_value, cond_value,
		output ready
	);
endinterface

// ----- sv/bss_rsp_if.sv -----
interface bss_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] next_pc;
	logic [31:0] next_link;
	logic [31:0] next_count;
	logic        taken;
	logic        not_branch;

	modport source (
		output valid, next_pc, next_link, next_count, taken, not_branch,
		input  ready
	);
	modport sink (
		input  valid, next_pc, next_link, next_count, taken, not_branch,
		output ready
	);
endinterface

// ----- sv/bss_exec.sv -----
module bss_exec (
	input  bss_pkg::req_item_t item,
	output bss_pkg::rsp_item_t result
);

	logic [5:0]  opc;
	logic [9:0]  xo;
	logic [4:0]  bo;
	logic [4:0]  bi;
	logic        aa;
	logic        lk;
	logic        is_b;
	logic        is_bc;
	logic        is_bclr;
	logic        is_bcctr;
	logic        use_ctr;
	logic [31:0] li;
	logic [31:0] bd;
	logic [31:0] offset;
	logic [31:0] rel_tgt;
	logic [31:0] pc4;
	logic [31:0] tgt;
	logic [31:0] new_ctr;
	logic [31:0] new_link;
	logic        ctr_ok;
	logic        cr_bit;
	logic        cond_ok;
	logic        go;

	assign opc = item.instr_word[31:26];
	assign xo  = item.instr_word[10:1];
	assign bo  = item.instr_word[25:21];
	assign bi  = item.instr_word[20:16];
	assign aa  = item.instr_word[1];
	assign lk  = item.instr_word[0];

	assign is_b     = (opc == bss_pkg::OPC_B);
	assign is_bc    = (opc == bss_pkg::OPC_BC);
	assign is_bclr  = (opc == bss_pkg::OPC_XL) && (xo == bss_pkg::XO_BCLR);
	assign is_bcctr = (opc == bss_pkg::OPC_XL) && (xo == bss_pkg::XO_BCCTR);
	assign use_ctr  = is_bc || is_bclr;

	assign li = {{6{item.instr_word[25]}}, item.instr_word[25:2], 2'b00};
	assign bd = {{16{item.instr_word[15]}}, item.instr_word[15:2], 2'b00};

	// one adder serves both relative forms
	assign offset  = is_b ? li : bd;
	assign rel_tgt = item.pc_value + offset;
	assign pc4     = item.pc_value + bss_pkg::PC_STEP;

	always_comb begin
		priority if (is_bclr) begin
			tgt = item.link_value;
		end else if (is_bcctr) begin
			tgt = item.count_value;
		end else if (aa) begin
			tgt = offset;
		end else begin
			tgt = rel_tgt;
		end
	end

	// bo bit 4 is ibm bo0, bit 1 is ibm bo3
	assign new_ctr  = (use_ctr && !bo[2]) ? (item.count_value - 32'd1) : item.count_value;
	assign ctr_ok   = !use_ctr || bo[2] || ((new_ctr != 32'd0) != bo[1]);
	assign cr_bit   = item.cond_value[~bi];
	assign cond_ok  = bo[4] || (cr_bit == bo[3]);
	assign new_link = lk ? pc4 : item.link_value;
	assign go       = is_b || (ctr_ok && cond_ok);

	always_comb begin
		if (is_b || is_bc || is_bclr || is_bcctr) begin
			result.next_pc    = go ? tgt : pc4;
			result.next_link  = new_link;
			result.next_count = new_ctr;
			result.taken      = go;
			result.not_branch = 1'b0;
		end else begin
			result.next_pc    = item.pc_value;
			result.next_link  = item.link_value;
			result.next_count = item.count_value;
			result.taken      = 1'b0;
			result.not_branch = 1'b1;
		end
	end

endmodule

// ----- sv/branch_single_step.sv -----
// branch_single_step: executes one branch instruction per beat.
// req channel: instruction word plus pc, link, count and condition
// registers; rsp channel: next pc, link and count plus taken and
// not_branch flags. one result beat for every request beat, in order.
// a request once accepted lands in the input register; its result is
// loaded into the output register when that register can advance and
// is visible from then on. throughput: one instruction per cycle while
// rsp.ready holds, set by the single decode and add path between
// the input and output registers.
// a stalled rsp holds its beat; the input register still takes one more
// request, after which req.ready drops until rsp.ready returns.
// reset (arst_n low) empties both registers at once; no beat is lost
// or repeated afterwards, and req.ready is high right after reset.
module branch_single_step (
	input  logic       clk,
	input  logic       arst_n,
	bss_req_if.sink    req,
	bss_rsp_if.source  rsp
);

	bss_pkg::req_item_t item_s1;
	bss_pkg::rsp_item_t exec_res;
	bss_pkg::rsp_item_t item_s2;
	logic               valid_s1;
	logic               valid_s2;
	logic               adv_s2;
	logic               load_s1;

	assign adv_s2    = !valid_s2 || rsp.ready;
	assign req.ready = !valid_s1 || adv_s2;
	assign load_s1   = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1.instr_word  <= req.instr_word;
			item_s1.pc_value    <= req.pc_value;
			item_s1.link_value  <= req.link_value;
			item_s1.count_value <= req.count_value;
			item_s1.cond_value  <= req.cond_value;
		end
		if (adv_s2 && valid_s1) begin
			item_s2 <= exec_res;
		end
	end

	bss_exec u_exec (
		.item   (item_s1),
		.result (exec_res)
	);

	assign rsp.valid      = valid_s2;
	assign rsp.next_pc    = item_s2.next_pc;
	assign rsp.next_link  = item_s2.next_link;
	assign rsp.next_count = item_s2.next_count;
	assign rsp.taken      = item_s2.taken;
	assign rsp.not_branch = item_s2.not_branch;

endmodule

// ----- sv/bss_checker.sv -----
`include "assert_macros.svh"

module bss_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] rsp_next_pc,
	input logic        rsp_taken,
	input logic        rsp_not_branch
);

	// a stalled result beat stays put
	`BSS_ASSERT(a_rsp_hold, clk, arst_n, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_next_pc)), "rsp beat changed while stalled")
	// non-branches never report taken
	`BSS_ASSERT(a_nb_not_taken, clk, arst_n, (rsp_valid && rsp_not_branch) |-> !rsp_taken, "taken set on a non-branch")
	// an empty output register never blocks the input
	`BSS_ASSERT(a_ready_when_empty, clk, arst_n, !rsp_valid |-> req_ready, "req stalled with empty output")
	// an accepted beat moves on from the input register to the output register when the receiver is ready
	`BSS_ASSERT(a_latency, clk, arst_n, (req_valid && req_ready) ##1 rsp_ready |=> rsp_valid, "result beat missing after accept")

endmodule

bind branch_single_step bss_checker u_bss_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_next_pc    (rsp.next_pc),
	.rsp_taken      (rsp.taken),
	.rsp_not_branch (rsp.not_branch)
);
